// File: rtl/core/octf_pkg.sv
package octf_pkg;

  // Default saturation limit of the reported text length.
  localparam logic [31:0] MaxTextLenDefault = 32'd65535;

  // Queue depths between the parts of the filter.
  localparam int CmdDepth = 4;
  localparam int OutDepth = 2;

  // Byte codes that the filter recognises or produces.
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] LigLead = 8'hEF;
  localparam logic [7:0] LigMid  = 8'hAC;
  localparam logic [7:0] LigFi   = 8'h81;
  localparam logic [7:0] LigFl   = 8'h82;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChI     = 8'h69;
  localparam logic [7:0] ChL     = 8'h6C;

  // One input word.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        last_of_text;
    logic [15:0] text_length;
  } out_word_t;

  // Command from the front part: up to two logical bytes, plus a flag for the end of a text.
  typedef struct packed {
    logic       eot;
    logic [1:0] nbytes;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } cmd_t;

  // Space, tab, LF, VT, FF and CR count as blanks.
  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == ChSpace) || ((b >= ChTab) && (b <= ChCr));
  endfunction

endpackage

// File: rtl/core/octf_fifo.sv
module octf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             wr_en;
  logic             rd_en;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign wr_en   = push && !full;
  assign rd_en   = pop && !empty;
  assign rd_data = store[rd_ptr];

  // Storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  // The fill level never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fifo fill level beyond depth");

  // A write without a read raises the fill level by one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !rd_en) |=> (count == $past(count) + 1'b1))
    else $error("fifo fill level did not follow a write");

  // A read without a write lowers the fill level by one.
  a_count_drop: assert property (@(posedge clk) disable iff (rst)
    (rd_en && !wr_en) |=> (count == $past(count) - 1'b1))
    else $error("fifo fill level did not follow a read");
`endif

endmodule

// File: rtl/core/octf_front.sv
module octf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  octf_pkg::in_word_t in_data,
  output logic              cmd_push,
  output octf_pkg::cmd_t    cmd
);

  logic [7:0] win0;
  logic [7:0] win1;
  logic [1:0] win_count;
  logic       leading_done;
  logic [7:0] win0_next;
  logic [7:0] win1_next;
  logic [1:0] win_count_next;
  logic       leading_done_next;
  logic [7:0] b;

  assign b = in_data.in_byte;

  // Classify the word: strip leading blanks, fill the window, match the patterns, flush at end of text.
  always_comb begin
    win0_next         = win0;
    win1_next         = win1;
    win_count_next    = win_count;
    leading_done_next = leading_done;
    cmd_push          = 1'b0;
    cmd               = '0;
    if (accept) begin
      if (in_data.end_of_text) begin
        // Flush whatever is pending and start afresh.
        cmd.eot           = 1'b1;
        cmd.nbytes        = win_count;
        cmd.byte0         = win0;
        cmd.byte1         = win1;
        cmd_push          = 1'b1;
        win_count_next    = '0;
        leading_done_next = 1'b0;
      end else if (leading_done || !octf_pkg::is_blank(b)) begin
        leading_done_next = 1'b1;
        if (win_count < 2'd2) begin
          if (win_count == 2'd0) begin
            win0_next = b;
          end else begin
            win1_next = b;
          end
          win_count_next = win_count + 2'd1;
        end else if ((win0 == octf_pkg::LigLead) && (win1 == octf_pkg::LigMid) &&
                     ((b == octf_pkg::LigFi) || (b == octf_pkg::LigFl))) begin
          // Ligature becomes two plain letters.
          cmd.nbytes     = 2'd2;
          cmd.byte0      = octf_pkg::ChF;
          cmd.byte1      = (b == octf_pkg::LigFi) ? octf_pkg::ChI : octf_pkg::ChL;
          cmd_push       = 1'b1;
          win_count_next = '0;
        end else if ((win0 == octf_pkg::ChLf) && (win1 == octf_pkg::ChSpace) &&
                     (b == octf_pkg::ChLf)) begin
          // LF space LF vanishes.
          win_count_next = '0;
        end else begin
          cmd.nbytes = 2'd1;
          cmd.byte0  = win0;
          cmd_push   = 1'b1;
          win0_next  = win1;
          win1_next  = b;
        end
      end
    end
  end

  // Window bytes hold payload only.
  always_ff @(posedge clk) begin
    win0 <= win0_next;
    win1 <= win1_next;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_count    <= '0;
      leading_done <= 1'b0;
    end else begin
      win_count    <= win_count_next;
      leading_done <= leading_done_next;
    end
  end

`ifndef SYNTH
  // The window never holds more than two bytes.
  a_win_bound: assert property (@(posedge clk) disable iff (rst)
    win_count <= 2'd2)
    else $error("window count beyond two");

  // Bytes enter the window only after the leading blanks are gone.
  a_win_lead: assert property (@(posedge clk) disable iff (rst)
    (win_count != 2'd0) |-> leading_done)
    else $error("window filled before leading blanks ended");

  // The end of a text leaves the window empty.
  a_eot_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.end_of_text) |=> (win_count == 2'd0 && !leading_done))
    else $error("state not cleared after end of text");
`endif

endmodule

// File: rtl/core/octf_back.sv
module octf_back #(
  parameter logic [31:0] MAX_TEXT_LEN = octf_pkg::MaxTextLenDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_empty,
  input  octf_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                out_full,
  output logic                out_push,
  output octf_pkg::out_word_t out_word
);

  localparam logic [15:0] LenLimit =
    (MAX_TEXT_LEN > 32'd65535) ? 16'hFFFF : MAX_TEXT_LEN[15:0];

  logic        held;
  logic        prev_nl;
  logic [15:0] count;
  logic [1:0]  idx;
  logic        held_next;
  logic        prev_nl_next;
  logic [15:0] count_next;
  logic [1:0]  idx_next;
  logic        step;
  logic        have_byte;
  logic [7:0]  b;
  logic        mark_push;

  assign step      = !cmd_empty && !out_full;
  assign have_byte = (idx < cmd.nbytes);
  assign b         = idx[0] ? cmd.byte1 : cmd.byte0;
  assign mark_push = out_push && out_word.last_of_text;

  // One result word at most per cycle; a held newline goes out before the next byte.
  always_comb begin
    logic adv;
    logic byte_out;
    adv          = 1'b0;
    byte_out     = 1'b0;
    held_next    = held;
    prev_nl_next = prev_nl;
    count_next   = count;
    idx_next     = idx;
    cmd_pop      = 1'b0;
    out_push     = 1'b0;
    out_word     = '0;
    if (step) begin
      if (have_byte) begin
        adv = 1'b1;
        if (held && (b != octf_pkg::ChLf)) begin
          // Release the held newline; the byte itself stays in place and goes out afterwards.
          out_word.out_byte = octf_pkg::ChLf;
          byte_out          = 1'b1;
          held_next         = 1'b0;
          adv               = 1'b0;
        end else if (held) begin
          // Held newline goes out, the new one is held in its place.
          out_word.out_byte = octf_pkg::ChLf;
          byte_out          = 1'b1;
          prev_nl_next      = 1'b1;
        end else if ((b == octf_pkg::ChLf) && prev_nl) begin
          held_next = 1'b1;
        end else begin
          out_word.out_byte = b;
          byte_out          = 1'b1;
          prev_nl_next      = (b == octf_pkg::ChLf);
        end
        if (byte_out) begin
          out_word.has_byte = 1'b1;
          out_push          = 1'b1;
          if (count < LenLimit) begin
            count_next = count + 16'd1;
          end
        end
        if (adv) begin
          if (((idx + 2'd1) == cmd.nbytes) && !cmd.eot) begin
            cmd_pop  = 1'b1;
            idx_next = '0;
          end else begin
            idx_next = idx + 2'd1;
          end
        end
      end else begin
        // Closing marker; any held newline is dropped.
        out_word.last_of_text = 1'b1;
        out_word.text_length  = count;
        out_push              = 1'b1;
        cmd_pop               = 1'b1;
        held_next             = 1'b0;
        prev_nl_next          = 1'b0;
        count_next            = '0;
        idx_next              = '0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= 1'b0;
      prev_nl <= 1'b0;
      count   <= '0;
      idx     <= '0;
    end else begin
      held    <= held_next;
      prev_nl <= prev_nl_next;
      count   <= count_next;
      idx     <= idx_next;
    end
  end

`ifndef SYNTH
  // A newline is held back only after a newline.
  a_held_prev: assert property (@(posedge clk) disable iff (rst)
    held |-> prev_nl)
    else $error("newline held without a preceding newline");

  // The length count stays within its limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= LenLimit)
    else $error("text length beyond limit");

  // After the closing marker the next text starts from a clean state.
  a_mark_clear: assert property (@(posedge clk) disable iff (rst)
    mark_push |=> (count == '0 && !held && !prev_nl && idx == '0))
    else $error("state not cleared after closing marker");

  // The closing marker only comes from an end-of-text command.
  a_mark_eot: assert property (@(posedge clk) disable iff (rst)
    mark_push |-> cmd.eot)
    else $error("closing marker without end of text");
`endif

endmodule

// File: rtl/core/ocr_text_cleanup_filter_top.sv
// Channel  | Direction | Handshake        | Word
// ---------+-----------+------------------+-----------------------------
// input    | in        | push / full      | in_data  (byte, end_of_text)
// result   | out       | pop / empty      | out_data (byte, flags, length)
//
// The front part takes one word per cycle while its command queue has room.
// The back part sends one result word per cycle while a command waits and the result
// queue has room; two logical bytes go out in turn, a byte behind a held newline waits,
// and an end-of-text word adds a closing marker. The command queue absorbs those bursts.
// Reset (rst, synchronous) empties both queues and clears all text state.
// A stalled result side fills the result queue, then the command queue, then
// raises full.
module ocr_text_cleanup_filter_top #(
  parameter logic [31:0] MAX_TEXT_LEN = octf_pkg::MaxTextLenDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  octf_pkg::in_word_t  in_data,
  output logic                empty,
  input  logic                pop,
  output octf_pkg::out_word_t out_data
);

  logic                accept;
  logic                cmd_push;
  octf_pkg::cmd_t      cmd_in;
  octf_pkg::cmd_t      cmd_out;
  logic                cmd_empty;
  logic                cmd_pop;
  logic                out_full;
  logic                out_push;
  octf_pkg::out_word_t out_word;

  assign accept = push && !full;

  // Front part: classification and window matching.
  octf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_data  (in_data),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // Command queue between the two parts.
  octf_fifo #(
    .WIDTH ($bits(octf_pkg::cmd_t)),
    .DEPTH (octf_pkg::CmdDepth)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .wr_data (cmd_in),
    .full    (full),
    .pop     (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  // Back part: newline hold-back, length count and closing marker.
  octf_back #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_word  (out_word)
  );

  // Result queue.
  octf_fifo #(
    .WIDTH ($bits(octf_pkg::out_word_t)),
    .DEPTH (octf_pkg::OutDepth)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (out_push),
    .wr_data (out_word),
    .full    (out_full),
    .pop     (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

endmodule
